[src/rlht_pkg.sv]
package rlht_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int ANGLE_W = 16;
  localparam int RATE_W = 16;
  localparam int TICK_W = 16;
  localparam int PROD_W = RATE_W + TICK_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_W = 8;
  localparam int XY_W = 28;
  localparam int TABLE_LEN = 24;
  localparam int TABLE_IDX_W = 5;
  localparam int STEP_SHIFT = 8;

  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATE = 2'd2;

  localparam logic signed [COORD_W-1:0] PIVOT_X_RESET = 16'sd400;
  localparam logic signed [COORD_W-1:0] PIVOT_Y_RESET = 16'sd300;
  localparam logic [RATE_W-1:0] TURN_RATE_RESET = 16'd699;

  function automatic logic [ANGLE_W-1:0] atan_unit(input logic [TABLE_IDX_W-1:0] idx);
    logic [ANGLE_W-1:0] v;
    case (idx)
      5'd0: v = 16'd8192;
      5'd1: v = 16'd4836;
      5'd2: v = 16'd2555;
      5'd3: v = 16'd1297;
      5'd4: v = 16'd651;
      5'd5: v = 16'd326;
      5'd6: v = 16'd163;
      5'd7: v = 16'd81;
      5'd8: v = 16'd41;
      5'd9: v = 16'd20;
      5'd10: v = 16'd10;
      5'd11: v = 16'd5;
      5'd12: v = 16'd3;
      5'd13: v = 16'd1;
      5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

[src/rlht_if.sv]
interface rlht_in_if;
  import rlht_pkg::*;

  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  logic [TICK_W-1:0] elapsed_ticks;

  modport source(output valid, output target_x, output target_y, output elapsed_ticks,
                 input ready);
  modport sink(input valid, input target_x, input target_y, input elapsed_ticks,
               output ready);
endinterface

interface rlht_out_if;
  import rlht_pkg::*;

  logic valid;
  logic ready;
  logic [ANGLE_W-1:0] heading;
  logic [ANGLE_W-1:0] bearing;
  logic on_target;

  modport source(output valid, output heading, output bearing, output on_target,
                 input ready);
  modport sink(input valid, input heading, input bearing, input on_target,
               output ready);
endinterface

[src/rlht_serial_mult.sv]
module rlht_serial_mult (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [rlht_pkg::RATE_W-1:0] a,
  input  logic [rlht_pkg::TICK_W-1:0] b,
  output logic busy,
  output logic [rlht_pkg::PROD_W-1:0] product
);
  import rlht_pkg::*;

  localparam int CNT_W = $clog2(TICK_W);

  logic [RATE_W-1:0] mcand;
  logic [TICK_W-1:0] mplier;
  logic [PROD_W-1:0] acc;
  logic [CNT_W-1:0] cnt;
  logic [RATE_W:0] sum;

  assign sum = {1'b0, acc[PROD_W-1:TICK_W]} + {1'b0, (mplier[0] ? mcand : '0)};
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(TICK_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      mplier <= b;
      acc <= '0;
    end else if (busy) begin
      mplier <= {1'b0, mplier[TICK_W-1:1]};
      acc <= {sum, acc[TICK_W-1:1]};
    end
  end

endmodule

[src/rlht_cordic.sv]
module rlht_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [rlht_pkg::DIFF_W-1:0] dx,
  input  logic signed [rlht_pkg::DIFF_W-1:0] dy,
  output logic busy,
  output logic [rlht_pkg::ANGLE_W-1:0] bearing
);
  import rlht_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic [ANGLE_W-1:0] z;
  logic zero_vec;
  logic [CNT_W-1:0] cnt;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic [ANGLE_W-1:0] rot;

  assign x0 = XY_W'(signed'({dx, {FRAC_W{1'b0}}}));
  assign y0 = XY_W'(signed'({dy, {FRAC_W{1'b0}}}));
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign rot = atan_unit(TABLE_IDX_W'(cnt));
  assign bearing = zero_vec ? '0 : z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_vec <= (dx == '0) && (dy == '0);
      if (dx[DIFF_W-1]) begin
        x <= -x0;
        y <= -y0;
        z <= HALF_TURN;
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (!y[XY_W-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + rot;
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - rot;
      end
    end
  end

endmodule

[src/rate_limited_heading_tracker.sv]
// An accepted transaction runs through the iterative CORDIC (one rotation per cycle) and the
// bit-serial rate multiplier in parallel. A new transaction is taken only in the idle state,
// once the previous result has been loaded into the output register.
// A finished result waits in the output register while the next transaction is taken.
// Synchronous active-high reset: heading 0, pivot (400, 300), turn rate 699, no result held.
module rate_limited_heading_tracker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  rlht_in_if.sink target,
  rlht_out_if.source result,
  input  logic cfg_we,
  input  logic [rlht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlht_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rlht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [COORD_W-1:0] pivot_x;
  logic signed [COORD_W-1:0] pivot_y;
  logic [RATE_W-1:0] turn_rate;
  logic [ANGLE_W-1:0] current_heading;

  logic accept;
  logic load_out;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic cordic_busy;
  logic mult_busy;
  logic [ANGLE_W-1:0] bearing;
  logic [PROD_W-1:0] product;

  logic [ANGLE_W-1:0] max_step;
  logic [ANGLE_W:0] b_plus_half;
  logic increase;
  logic [ANGLE_W-1:0] distance;
  logic [ANGLE_W-1:0] step;
  logic [ANGLE_W-1:0] heading_next;

  logic out_valid;
  logic [ANGLE_W-1:0] out_heading;
  logic [ANGLE_W-1:0] out_bearing;
  logic out_on_target;

  assign target.ready = (state == S_IDLE);
  assign accept = target.valid && target.ready;
  assign load_out = (state == S_DONE) && (!out_valid || result.ready);

  assign dx = DIFF_W'(target.target_x) - DIFF_W'(pivot_x);
  assign dy = DIFF_W'(target.target_y) - DIFF_W'(pivot_y);

  rlht_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .dx(dx),
    .dy(dy),
    .busy(cordic_busy),
    .bearing(bearing)
  );

  rlht_serial_mult u_mult (
    .clk(clk),
    .rst(rst),
    .start(accept),
    .a(turn_rate),
    .b(target.elapsed_ticks),
    .busy(mult_busy),
    .product(product)
  );

  always_comb begin
    if (product[PROD_W-1:ANGLE_W+STEP_SHIFT-1] != '0) begin
      max_step = HALF_TURN;
    end else begin
      max_step = {1'b0, product[ANGLE_W+STEP_SHIFT-2:STEP_SHIFT]};
    end
    b_plus_half = {1'b0, bearing} + {1'b0, HALF_TURN};
    if (bearing < current_heading) begin
      increase = !(b_plus_half >= {1'b0, current_heading});
    end else begin
      increase = !(bearing[ANGLE_W-1] && ((bearing - HALF_TURN) > current_heading));
    end
    distance = increase ? (bearing - current_heading) : (current_heading - bearing);
    step = (distance < max_step) ? distance : max_step;
    heading_next = increase ? (current_heading + step) : (current_heading - step);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_RUN;
      S_RUN: if (!cordic_busy && !mult_busy) state_next = S_DONE;
      S_DONE: if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      current_heading <= '0;
      out_valid <= 1'b0;
      pivot_x <= PIVOT_X_RESET;
      pivot_y <= PIVOT_Y_RESET;
      turn_rate <= TURN_RATE_RESET;
    end else begin
      state <= state_next;
      if (load_out) begin
        current_heading <= heading_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PIVOT_X: pivot_x <= COORD_W'(cfg_data);
          CFG_PIVOT_Y: pivot_y <= COORD_W'(cfg_data);
          CFG_TURN_RATE: turn_rate <= RATE_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_heading <= heading_next;
      out_bearing <= bearing;
      out_on_target <= (heading_next == bearing);
    end
  end

  assign result.valid = out_valid;
  assign result.heading = out_heading;
  assign result.bearing = out_bearing;
  assign result.on_target = out_on_target;

endmodule

[sim/rate_limited_heading_tracker_tb.sv]
`timescale 1ns / 1ps

module rate_limited_heading_tracker_tb;
  import rlht_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int TRACK_STEPS = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_AIMS = 106;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [TICK_W-1:0] ticks;
  } aim_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] heading;
    logic [ANGLE_W-1:0] bearing;
    logic on_target;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rlht_in_if aim_ch();
  rlht_out_if pose_ch();

  rate_limited_heading_tracker uut (
    .clk(clk),
    .rst(rst),
    .target(aim_ch),
    .result(pose_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  const int atan_lut [TRACK_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                       41, 20, 10, 5, 3, 1, 1, 0};

  logic signed [COORD_W-1:0] model_pivot_x = PIVOT_X_RESET;
  logic signed [COORD_W-1:0] model_pivot_y = PIVOT_Y_RESET;
  logic [RATE_W-1:0] model_turn_rate = TURN_RATE_RESET;
  logic [ANGLE_W-1:0] model_heading = '0;

  aim_t pending_aims[$];
  pose_t expected_poses[$];
  int aims_sent = 0;
  int poses_seen = 0;
  int mismatches = 0;
  int missing_poses = 0;
  int settings_used = 1;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  wire steady = (aims_sent >= 250) && (aims_sent < 330);

  function automatic logic [ANGLE_W-1:0] bearing_of(input logic signed [DIFF_W-1:0] dx,
                                                    input logic signed [DIFF_W-1:0] dy);
    longint x, y, z, xs, ys;
    if (dx == 0 && dy == 0) return '0;
    x = longint'(dx) * 256;
    y = longint'(dy) * 256;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < TRACK_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_lut[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_lut[i];
      end
    end
    return ANGLE_W'(z);
  endfunction

  function automatic pose_t track_target(input aim_t a, input logic [ANGLE_W-1:0] cur);
    logic signed [DIFF_W-1:0] dx, dy;
    logic [PROD_W-1:0] prod;
    int b, h, max_step, distance, step;
    bit increase;
    pose_t p;
    dx = a.x - model_pivot_x;
    dy = a.y - model_pivot_y;
    b = int'(bearing_of(dx, dy));
    h = int'(cur);
    prod = PROD_W'(model_turn_rate) * PROD_W'(a.ticks);
    max_step = int'(prod >> STEP_SHIFT);
    if (max_step > 32768) max_step = 32768;
    if (b < h) increase = !(b + 32768 >= h);
    else increase = !(b >= 32768 && b - 32768 > h);
    distance = (increase ? b - h : h - b) & 16'hFFFF;
    step = (distance < max_step) ? distance : max_step;
    h = (increase ? h + step : h - step) & 16'hFFFF;
    p.heading = ANGLE_W'(h);
    p.bearing = ANGLE_W'(b);
    p.on_target = (h == b);
    return p;
  endfunction

  function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 128)) - 64;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return COORD_W'(v);
  endfunction

  function automatic aim_t random_aim();
    aim_t a;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      a.x = model_pivot_x;
      a.y = model_pivot_y;
    end else if (mode <= 3) begin
      a.x = near(model_pivot_x);
      a.y = near(model_pivot_y);
    end else begin
      a.x = COORD_W'($urandom);
      a.y = COORD_W'($urandom);
    end
    mode = $urandom_range(0, 9);
    if (mode < 4) a.ticks = TICK_W'($urandom_range(0, 63));
    else if (mode < 8) a.ticks = TICK_W'($urandom_range(0, 1023));
    else a.ticks = TICK_W'($urandom);
    return a;
  endfunction

  task automatic queue_aim(input int x, input int y, input int ticks);
    aim_t a;
    a.x = COORD_W'(x);
    a.y = COORD_W'(y);
    a.ticks = TICK_W'(ticks);
    pending_aims.push_back(a);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PIVOT_X: model_pivot_x = val;
      CFG_PIVOT_Y: model_pivot_y = val;
      CFG_TURN_RATE: model_turn_rate = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_aims.size() != 0 || expected_poses.size() != 0 || aim_ch.valid);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: hold the offered transaction until it is taken
  always @(posedge clk) begin
    aim_t cur;
    pose_t want;
    logic offer;
    if (rst) begin
      aim_ch.valid <= 1'b0;
      aim_ch.target_x <= '0;
      aim_ch.target_y <= '0;
      aim_ch.elapsed_ticks <= '0;
    end else begin
      offer = aim_ch.valid;
      if (aim_ch.valid && aim_ch.ready) begin
        cur = pending_aims.pop_front();
        want = track_target(cur, model_heading);
        model_heading = want.heading;
        expected_poses.push_back(want);
        aims_sent <= aims_sent + 1;
        offer = 1'b0;
      end
      if (!offer && pending_aims.size() != 0 && (steady || $urandom_range(0, 99) >= 12)) begin
        cur = pending_aims[0];
        aim_ch.target_x <= cur.x;
        aim_ch.target_y <= cur.y;
        aim_ch.elapsed_ticks <= cur.ticks;
        offer = 1'b1;
      end
      aim_ch.valid <= offer;
    end
  end

  // receiver: one long hold-off so the block backs up, random stalls otherwise except in the steady window
  always @(posedge clk) begin
    if (rst) begin
      pose_ch.ready <= 1'b0;
    end else if (!hold_done && aims_sent >= 100) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pose_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pose_ch.ready <= 1'b0;
    end else begin
      pose_ch.ready <= steady || ($urandom_range(0, 99) >= 12);
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (!rst && pose_ch.valid && pose_ch.ready) begin
      poses_seen++;
      if (expected_poses.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected transaction: heading %0d bearing %0d on_target %0d",
                   pose_ch.heading, pose_ch.bearing, pose_ch.on_target);
        mismatches++;
      end else begin
        want = expected_poses.pop_front();
        if (pose_ch.heading !== want.heading || pose_ch.bearing !== want.bearing ||
            pose_ch.on_target !== want.on_target) begin
          if (mismatches < 10)
            $display("mismatch at %0t: heading %0d/%0d bearing %0d/%0d on_target %0d/%0d",
                     $realtime, want.heading, pose_ch.heading, want.bearing,
                     pose_ch.bearing, want.on_target, pose_ch.on_target);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (aim_ch.valid && aim_ch.ready) || (pose_ch.valid && pose_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: zero vector, half-turn ties both ways, axes and corners
    queue_aim(400, 300, 100);
    queue_aim(1400, 600, 65535);
    queue_aim(-600, 0, 10);
    queue_aim(-600, 0, 65535);
    queue_aim(1400, 600, 10);
    queue_aim(1400, 600, 0);
    queue_aim(32767, 32767, 65535);
    queue_aim(-32768, -32768, 1);
    queue_aim(-32768, 32767, 300);
    queue_aim(32767, -32768, 65535);
    queue_aim(400, 32767, 65535);
    queue_aim(400, -32768, 65535);
    queue_aim(-32768, 300, 65535);
    queue_aim(32767, 300, 65535);
    queue_aim(401, 300, 1);
    queue_aim(399, 301, 255);
    queue_aim(-32768, -32767, 65535);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_PIVOT_X, CFG_DATA_W'($urandom));
          write_reg(CFG_PIVOT_Y, CFG_DATA_W'($urandom));
          write_reg(CFG_TURN_RATE, CFG_DATA_W'($urandom_range(0, 4095)));
        end
        1: begin
          write_reg(CFG_PIVOT_X, 16'h8000);
          write_reg(CFG_PIVOT_Y, 16'h8000);
          write_reg(CFG_TURN_RATE, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_PIVOT_X, 16'h7FFF);
          write_reg(CFG_PIVOT_Y, 16'h7FFF);
          write_reg(CFG_TURN_RATE, 16'h0000);
          write_reg(CFG_SPARE, 16'hFFFF);
        end
        3: begin
          write_reg(CFG_PIVOT_X, 16'h0000);
          write_reg(CFG_PIVOT_Y, 16'h0000);
          write_reg(CFG_TURN_RATE, 16'h0001);
        end
        default: begin
          write_reg(CFG_PIVOT_X, CFG_DATA_W'($urandom));
          write_reg(CFG_PIVOT_Y, CFG_DATA_W'($urandom));
          write_reg(CFG_TURN_RATE, TURN_RATE_RESET);
        end
      endcase
      settings_used++;
      @(negedge clk);
      repeat (PHASE_AIMS) pending_aims.push_back(random_aim());
      drain();
    end

    if (expected_poses.size() != 0) begin
      $display("%0d expected transactions never arrived", expected_poses.size());
      missing_poses = expected_poses.size();
    end
    $display("covered %0d heading updates over %0d register settings, %0d results checked",
             aims_sent, settings_used, poses_seen);
    $display("including a %0d cycle receiver hold-off, %0d mismatches", HOLD_CYCLES,
             mismatches + missing_poses);
    if (mismatches == 0 && missing_poses == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
src/rlht_pkg.sv
src/rlht_if.sv
src/rlht_serial_mult.sv
src/rlht_cordic.sv
src/rate_limited_heading_tracker.sv
sim/rate_limited_heading_tracker_tb.sv
